### hw/rtl/i2cee_pkg.sv
// Shared types, codes and sequence tables of the serial EEPROM byte access master.
package i2cee_pkg;

    localparam int SEG_W = 5;

    localparam logic [SEG_W-1:0] SEG_IDLE = 5'd0;

    typedef logic [3:0] t_kind;

    localparam t_kind K_START  = 4'd0;
    localparam t_kind K_TXDEV  = 4'd1;
    localparam t_kind K_TXADDR = 4'd2;
    localparam t_kind K_TXDATA = 4'd3;
    localparam t_kind K_TXDEVR = 4'd4;
    localparam t_kind K_ACK    = 4'd5;
    localparam t_kind K_RX     = 4'd6;
    localparam t_kind K_NACK   = 4'd7;
    localparam t_kind K_STOP   = 4'd8;
    localparam t_kind K_ONES   = 4'd9;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;
    localparam logic [1:0] OP_BUSRESET = 2'd3;

    localparam logic [7:0] DEV_BASE_RST = 8'hA0;
    localparam logic [3:0] TX_BITS      = 4'd8;
    localparam logic [3:0] ONES_BITS    = 4'd9;

    localparam logic [SEG_W-1:0] STOP_POS_WR  = 5'd8;
    localparam logic [SEG_W-1:0] STOP_POS_RD  = 5'd11;
    localparam logic [SEG_W-1:0] STOP_POS_RST = 5'd4;

    localparam t_kind SEQ_WR [8] = '{K_START, K_TXDEV, K_ACK, K_TXADDR, K_ACK,
                                     K_TXDATA, K_ACK, K_STOP};
    localparam t_kind SEQ_RD [11] = '{K_START, K_TXDEV, K_ACK, K_TXADDR, K_ACK,
                                      K_START, K_TXDEVR, K_ACK, K_RX, K_NACK, K_STOP};
    localparam t_kind SEQ_RST [4] = '{K_START, K_ONES, K_START, K_STOP};

    typedef struct packed {
        logic [SEG_W-1:0] segment;
        logic [1:0]       line_step;
        logic [3:0]       bit_count;
        logic [7:0]       tx_shift;
        logic [7:0]       rx_shift;
        logic [1:0]       op;
        logic [7:0]       addr;
        logic [2:0]       page;
        logic [7:0]       data;
        logic             scl;
        logic             sda;
        logic             err;
    } t_state;

    localparam t_state STATE_RST = '{
        segment: SEG_IDLE, line_step: 2'd0, bit_count: 4'd0, tx_shift: 8'd0,
        rx_shift: 8'd0, op: OP_TICK, addr: 8'd0, page: 3'd0, data: 8'd0,
        scl: 1'b1, sda: 1'b1, err: 1'b0
    };

    function automatic t_kind seg_kind(input logic [1:0] op, input logic [SEG_W-1:0] pos);
        logic [SEG_W-1:0] idx;
        t_kind            k;
        idx = pos - 5'd1;
        k   = K_STOP;
        if (pos != SEG_IDLE) begin
            if (op == OP_WRITE && idx < 5'd8) begin
                k = SEQ_WR[idx[2:0]];
            end else if (op == OP_READ && idx < 5'd11) begin
                k = SEQ_RD[idx[3:0]];
            end else if (op == OP_BUSRESET && idx < 5'd4) begin
                k = SEQ_RST[idx[1:0]];
            end
        end
        return k;
    endfunction

    function automatic logic [SEG_W-1:0] stop_pos(input logic [1:0] op);
        logic [SEG_W-1:0] p;
        p = STOP_POS_RST;
        if (op == OP_WRITE) begin
            p = STOP_POS_WR;
        end else if (op == OP_READ) begin
            p = STOP_POS_RD;
        end
        return p;
    endfunction

    function automatic t_state enter_seg(input t_state s, input logic [SEG_W-1:0] pos,
                                         input logic [7:0] base);
        t_state n;
        t_kind  k;
        n           = s;
        n.segment   = pos;
        n.line_step = 2'd0;
        n.bit_count = 4'd0;
        k           = seg_kind(s.op, pos);
        if (k == K_TXDEV) begin
            n.tx_shift = base | {4'd0, s.page, 1'b0};
        end else if (k == K_TXDEVR) begin
            n.tx_shift = base | {4'd0, s.page, 1'b1};
        end else if (k == K_TXADDR) begin
            n.tx_shift = s.addr;
        end else if (k == K_TXDATA) begin
            n.tx_shift = s.data;
        end
        return n;
    endfunction

endpackage

### hw/rtl/i2cee_in_if.sv
// Input channel: command or tick beat with sampled data line.
interface i2cee_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] word_addr;
    logic [2:0] page;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, kind, word_addr, page, write_data, sda_in, input ready);
    modport sink (input valid, kind, word_addr, page, write_data, sda_in, output ready);
endinterface

### hw/rtl/i2cee_out_if.sv
// Output channel: line levels and status after each beat.
interface i2cee_out_if;
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;

    modport source (output valid, scl, sda_out, busy_res, done_res, read_data, ack_error,
                    input ready);
    modport sink (input valid, scl, sda_out, busy_res, done_res, read_data, ack_error,
                  output ready);
endinterface

### hw/rtl/i2cee_step.sv
// Next-state logic: command latch and one line step per beat.
module i2cee_step
    import i2cee_pkg::*;
(
    input  t_state     i_cur,
    input  logic [7:0] i_base,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_word_addr,
    input  logic [2:0] i_page,
    input  logic [7:0] i_write_data,
    input  logic       i_sda_in,
    output t_state     o_nxt,
    output logic       o_done
);

    t_state s;
    t_state n;
    t_kind  k;
    logic   done;

    always_comb begin
        s = i_cur;
        if (i_cur.segment == SEG_IDLE && i_kind != OP_TICK) begin
            s.op   = i_kind;
            s.addr = i_word_addr;
            s.page = i_page;
            s.data = i_write_data;
            s.err  = 1'b0;
            s      = enter_seg(s, 5'd1, i_base);
        end

        n    = s;
        done = 1'b0;
        k    = seg_kind(s.op, s.segment);

        if (s.segment != SEG_IDLE) begin
            unique case (k) inside
                K_START: begin
                    unique case (s.bit_count)
                        4'd0: n.scl = 1'b0;
                        4'd1: n.sda = 1'b1;
                        4'd2: n.scl = 1'b1;
                        4'd3: n.sda = 1'b0;
                        default: begin
                            n.scl = 1'b0;
                            n     = enter_seg(n, s.segment + 5'd1, i_base);
                        end
                    endcase
                    if (s.bit_count < 4'd4) begin
                        n.bit_count = s.bit_count + 4'd1;
                    end
                end
                K_TXDEV, K_TXADDR, K_TXDATA, K_TXDEVR: begin
                    if (s.bit_count >= TX_BITS) begin
                        n.sda = 1'b1;
                        n     = enter_seg(n, s.segment + 5'd1, i_base);
                    end else if (s.line_step == 2'd0) begin
                        n.sda       = s.tx_shift[7];
                        n.line_step = 2'd1;
                    end else if (s.line_step == 2'd1) begin
                        n.scl       = 1'b1;
                        n.line_step = 2'd2;
                    end else begin
                        n.scl       = 1'b0;
                        n.tx_shift  = {s.tx_shift[6:0], 1'b0};
                        n.bit_count = s.bit_count + 4'd1;
                        n.line_step = 2'd0;
                    end
                end
                K_ACK: begin
                    if (s.line_step == 2'd0) begin
                        n.scl       = 1'b1;
                        n.line_step = 2'd1;
                    end else begin
                        n.scl = 1'b0;
                        if (i_sda_in) begin
                            n.err = 1'b1;
                            n     = enter_seg(n, stop_pos(s.op), i_base);
                        end else begin
                            n = enter_seg(n, s.segment + 5'd1, i_base);
                        end
                    end
                end
                K_RX: begin
                    if (s.line_step == 2'd0) begin
                        n.sda       = 1'b1;
                        n.line_step = 2'd1;
                    end else if (s.line_step == 2'd1) begin
                        n.scl       = 1'b1;
                        n.line_step = 2'd2;
                    end else begin
                        n.scl       = 1'b0;
                        n.rx_shift  = {s.rx_shift[6:0], i_sda_in};
                        n.bit_count = s.bit_count + 4'd1;
                        if (n.bit_count >= TX_BITS) begin
                            n = enter_seg(n, s.segment + 5'd1, i_base);
                        end else begin
                            n.line_step = 2'd1;
                        end
                    end
                end
                K_NACK: begin
                    if (s.line_step == 2'd0) begin
                        n.sda       = 1'b1;
                        n.line_step = 2'd1;
                    end else if (s.line_step == 2'd1) begin
                        n.scl       = 1'b1;
                        n.line_step = 2'd2;
                    end else begin
                        n.scl = 1'b0;
                        n     = enter_seg(n, s.segment + 5'd1, i_base);
                    end
                end
                K_ONES: begin
                    if (s.line_step == 2'd0) begin
                        n.sda       = 1'b1;
                        n.line_step = 2'd1;
                    end else if (s.line_step == 2'd1) begin
                        n.scl       = 1'b1;
                        n.line_step = 2'd2;
                    end else begin
                        n.scl       = 1'b0;
                        n.bit_count = s.bit_count + 4'd1;
                        n.line_step = 2'd0;
                        if (n.bit_count >= ONES_BITS) begin
                            n = enter_seg(n, s.segment + 5'd1, i_base);
                        end
                    end
                end
                default: begin
                    unique case (s.line_step)
                        2'd0: begin
                            n.scl       = 1'b0;
                            n.line_step = 2'd1;
                        end
                        2'd1: begin
                            n.sda       = 1'b0;
                            n.line_step = 2'd2;
                        end
                        2'd2: begin
                            n.scl       = 1'b1;
                            n.line_step = 2'd3;
                        end
                        default: begin
                            n.sda       = 1'b1;
                            n.segment   = SEG_IDLE;
                            n.line_step = 2'd0;
                            n.bit_count = 4'd0;
                            done        = 1'b1;
                        end
                    endcase
                end
            endcase
        end
    end

    assign o_nxt  = n;
    assign o_done = done;

endmodule

### hw/rtl/i2c_eeprom_byte_access_master.sv
// Serial EEPROM byte write / random read master, one line change per beat.
// The result of a beat is registered and appears on the output channel in the cycle after acceptance.
// Throughput: one beat per cycle; the next beat is taken while a result waits if the
// output register is being drained in the same cycle.
// Reset: synchronous, active low; idle, both lines released, device base 0xA0.
module i2c_eeprom_byte_access_master
    import i2cee_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2cee_in_if.sink   i_in,
    i2cee_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    t_state     r_state;
    t_state     n_state;
    logic [7:0] r_base;
    logic       r_out_valid;
    logic       r_done;
    logic       n_done;
    logic       w_accept;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    i2cee_step u_step (
        .i_cur        (r_state),
        .i_base       (r_base),
        .i_kind       (i_in.kind),
        .i_word_addr  (i_in.word_addr),
        .i_page       (i_in.page),
        .i_write_data (i_in.write_data),
        .i_sda_in     (i_in.sda_in),
        .o_nxt        (n_state),
        .o_done       (n_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= DEV_BASE_RST;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RST;
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state     <= n_state;
                r_done      <= n_done;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.scl       = r_state.scl;
    assign o_out.sda_out   = r_state.sda;
    assign o_out.busy_res  = (r_state.segment != SEG_IDLE);
    assign o_out.done_res  = r_done;
    assign o_out.read_data = r_state.rx_shift;
    assign o_out.ack_error = r_state.err;

endmodule
